// ===== src/base64_stream_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit_assert.svh
// Assertion macros shared by the front and queue modules. Each one expects clk and
// arst_n to be in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define B64SD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define B64SD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/b64sd_pkg.sv =====
// ----------------------------------------------------------------------------
// b64sd_pkg
// Types, constants and the character classifier of the Base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64sd_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] PAD_CHAR     = 8'h3D;
	localparam logic [6:0] SEXTET_PAD   = 7'd64;
	localparam logic [6:0] SEXTET_BAD   = 7'd65;
	localparam logic [1:0] GRP_LAST_POS = 2'd3;
	localparam logic [1:0] GRP_BYTES    = 2'd3;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_string;
	} char_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		logic       error;
	} res_t;

	// one finished group: up to three bytes, or a single error result
	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  count;
		logic        eos;
		logic        err;
	} grp_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [6:0] classify(input logic [7:0] c);
		logic [6:0] v;
		v = SEXTET_BAD;
		if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h47);
		else if (c >= 8'h30 && c <= 8'h39) v = 7'(c + 8'd4);
		else if (c == 8'h2B) v = 7'd62;
		else if (c == 8'h2F) v = 7'd63;
		else if (c == PAD_CHAR) v = SEXTET_PAD;
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== src/b64sd_front.sv =====
// ----------------------------------------------------------------------------
// b64sd_front
// Accepts characters, classifies them, checks padding and length, and
// collects groups of four sextets into queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base64_stream_decoder_unit_assert.svh"

module b64sd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              char_valid,
	input  wire b64sd_pkg::char_t  char_data,
	input  wire logic              q_full,
	output logic                   char_stall,
	output logic                   push,
	output b64sd_pkg::grp_t        grp
);
	import b64sd_pkg::*;

	logic [1:0]  pos_q;
	logic [17:0] acc_q;
	logic [1:0]  pcnt_q;
	logic        pseen_q;
	logic        err_q;

	logic        accept;
	logic        eos;
	logic [6:0]  sextet;
	logic        bad;
	logic [1:0]  pc_n;
	logic        pseen_n;
	logic [5:0]  val;

	assign char_stall = q_full;
	assign accept     = char_valid && !char_stall;
	assign eos        = char_data.end_of_string;
	assign sextet     = classify(char_data.char_code);

	always_comb begin
		bad     = 1'b0;
		pc_n    = pcnt_q;
		pseen_n = pseen_q;
		val     = '0;
		priority if (err_q) begin
			bad = 1'b1;
		end else if (sextet == SEXTET_BAD) begin
			bad = 1'b1;
		end else if (sextet == SEXTET_PAD) begin
			if (pos_q < 2'd2) begin
				bad = 1'b1;
			end else begin
				pc_n    = pcnt_q + 2'd1;
				pseen_n = 1'b1;
			end
		end else begin
			if (pseen_q) bad = 1'b1;
			else val = sextet[5:0];
		end
		if (!bad) begin
			if (pos_q == GRP_LAST_POS) begin
				if (pseen_n && !eos) bad = 1'b1;
			end else if (eos) begin
				bad = 1'b1;
			end
		end
	end

	assign push = accept && ((bad && eos) || (!bad && pos_q == GRP_LAST_POS));

	always_comb begin
		if (bad) begin
			grp.word  = '0;
			grp.count = 2'd1;
			grp.eos   = 1'b1;
			grp.err   = 1'b1;
		end else begin
			grp.word  = {acc_q, val};
			grp.count = GRP_BYTES - pc_n;
			grp.eos   = eos;
			grp.err   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			acc_q   <= '0;
			pcnt_q  <= '0;
			pseen_q <= 1'b0;
			err_q   <= 1'b0;
		end else if (accept) begin
			if (push) begin
				pos_q   <= '0;
				acc_q   <= '0;
				pcnt_q  <= '0;
				pseen_q <= 1'b0;
				err_q   <= 1'b0;
			end else if (bad) begin
				err_q <= 1'b1;
			end else begin
				pos_q   <= pos_q + 2'd1;
				acc_q   <= {acc_q[11:0], val};
				pcnt_q  <= pc_n;
				pseen_q <= pseen_n;
			end
		end
	end

	`B64SD_ASSERT_NOW(a_err_entry_single, push && grp.err, grp.count == 2'd1 && grp.eos, "error entry must be a single closing result")
	`B64SD_ASSERT_NEXT(a_eos_clears, accept && eos, pos_q == 2'd0 && !err_q && !pseen_q, "state not cleared at end of string")
	`B64SD_ASSERT_NEXT(a_err_holds, accept && err_q && !eos, err_q, "error flag dropped inside a string")
	`B64SD_ASSERT_NOW(a_count_range, push, grp.count != 2'd0, "queue entry with no bytes")

endmodule

`default_nettype wire

// ===== src/b64sd_queue.sv =====
// ----------------------------------------------------------------------------
// b64sd_queue
// Short queue of group entries between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base64_stream_decoder_unit_assert.svh"

module b64sd_queue #(
	parameter int unsigned DEPTH = b64sd_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire b64sd_pkg::grp_t     wr_grp,
	input  wire logic                pop,
	output b64sd_pkg::grp_t          rd_grp,
	output b64sd_pkg::q_status_t     status
);
	import b64sd_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	grp_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign status.full  = (cnt_q == FULL_CNT);
	assign status.empty = (cnt_q == '0);
	assign rd_grp       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	`B64SD_ASSERT_NOW(a_no_overflow, push, !status.full, "push into full queue")
	`B64SD_ASSERT_NOW(a_no_underflow, pop, !status.empty, "pop from empty queue")
	`B64SD_ASSERT_NEXT(a_count_up, push && !pop, cnt_q == $past(cnt_q) + CW'(1), "queue count lost a push")

endmodule

`default_nettype wire

// ===== src/b64sd_back.sv =====
// ----------------------------------------------------------------------------
// b64sd_back
// Unpacks queue entries into result bytes, one per cycle while res_stall is
// low, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sd_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire b64sd_pkg::grp_t      head,
	input  wire b64sd_pkg::q_status_t status,
	output logic                      pop,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output b64sd_pkg::res_t           res_data
);
	import b64sd_pkg::*;

	logic [1:0] idx_q;
	logic       res_valid_q;
	res_t       res_q;
	logic       load;
	logic       last_byte;
	logic [7:0] byte_sel;

	assign load      = !status.empty && (!res_valid_q || !res_stall);
	assign last_byte = (idx_q == head.count - 2'd1);
	assign pop       = load && last_byte;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_comb begin
		unique case (idx_q)
			2'd0:    byte_sel = head.word[23:16];
			2'd1:    byte_sel = head.word[15:8];
			2'd2:    byte_sel = head.word[7:0];
			default: byte_sel = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.data_byte <= head.err ? 8'd0 : byte_sel;
			res_q.last      <= head.eos && last_byte;
			res_q.error     <= head.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (!res_valid_q || !res_stall) res_valid_q <= !status.empty;
			if (load) idx_q <= last_byte ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

// ===== src/base64_stream_decoder_unit.sv =====
// Base64 decoder: one character accepted per cycle while char_stall is low.
// A group's bytes are written to the queue when its fourth character is
// accepted, then loaded into the output register; they follow one per cycle while res_stall is low.
// Throughput is set by the byte unpacker (one byte per cycle unless stalled,
// at most three per four characters) and a queue of QUEUE_DEPTH groups between the parts.
// Reset (arst_n low) clears group state, queue and output valid at once.
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Top level: front classifier, group queue and byte unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = b64sd_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              char_valid,
	output logic                   char_stall,
	input  wire b64sd_pkg::char_t  char_data,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output b64sd_pkg::res_t        res_data
);
	import b64sd_pkg::*;

	logic      push;
	logic      pop;
	grp_t      wr_grp;
	grp_t      rd_grp;
	q_status_t q_status;

	b64sd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_data  (char_data),
		.q_full     (q_status.full),
		.char_stall (char_stall),
		.push       (push),
		.grp        (wr_grp)
	);

	b64sd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_grp (wr_grp),
		.pop    (pop),
		.rd_grp (rd_grp),
		.status (q_status)
	);

	b64sd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (rd_grp),
		.status    (q_status),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench of the Base64 stream decoder. Characters go in through a bursty
// sender, one request per character. A model of the group state in this
// file works out the bytes and error results that each accepted request
// causes. A monitor compares every result taken from the block, field by
// field and in order. The receiver stalls in random runs, and once holds off
// long enough to fill the block. Directed strings cover the alphabet edges,
// padding and a range of malformed cases. Random strings follow, most of them
// well formed.
// ----------------------------------------------------------------------------

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import b64sd_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_TAIL = 16;
	localparam int PRINT_CAP  = 50;

	typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_e;

	logic  clk        = 1'b0;
	logic  arst_n     = 1'b0;
	logic  char_valid = 1'b0;
	logic  char_stall;
	char_t char_data  = '0;
	logic  res_valid;
	logic  res_stall  = 1'b0;
	res_t  res_data;

	res_t        decoded_bytes[$];
	logic [1:0]  grp_pos   = '0;
	logic [17:0] grp_acc   = '0;
	logic [1:0]  pad_cnt   = '0;
	logic        pad_seen  = 1'b0;
	logic        str_err   = 1'b0;

	int       err_count      = 0;
	int       idle_cycles    = 0;
	int       burst_left     = 0;
	int       hold_off_len   = 0;
	bit       sender_gapless = 1'b0;
	rx_mode_e rx_mode        = RX_LIGHT;

	base64_stream_decoder_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

	always #5 clk = ~clk;

	function automatic bit sextet_of(input logic [7:0] c, output logic [5:0] v);
		v = '0;
		if (c >= "A" && c <= "Z") v = 6'(c - "A");
		else if (c >= "a" && c <= "z") v = 6'(c - "a" + 26);
		else if (c >= "0" && c <= "9") v = 6'(c - "0" + 52);
		else if (c == "+") v = 6'd62;
		else if (c == "/") v = 6'd63;
		else return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [7:0] rand_b64();
		int i;
		i = $urandom_range(0, 63);
		if (i < 26) return 8'("A" + i);
		if (i < 52) return 8'("a" + i - 26);
		if (i < 62) return 8'("0" + i - 52);
		return (i == 62) ? 8'("+") : 8'("/");
	endfunction

	task automatic clear_group();
		grp_pos  = '0;
		grp_acc  = '0;
		pad_cnt  = '0;
		pad_seen = 1'b0;
		str_err  = 1'b0;
	endtask

	task automatic add_expected(input res_t r);
		decoded_bytes = {decoded_bytes, r};
	endtask

	task automatic decode_char(input char_t ch);
		logic [5:0]  v;
		logic        is_data;
		logic        bad;
		logic [1:0]  pc;
		logic        ps;
		logic [23:0] word;
		int          n;
		is_data = sextet_of(ch.char_code, v);
		pc = pad_cnt;
		ps = pad_seen;
		bad = 1'b0;
		if (str_err) begin
			bad = 1'b1;
		end else if (ch.char_code == PAD_CHAR) begin
			if (grp_pos < 2) begin
				bad = 1'b1;
			end else begin
				pc = pc + 1'b1;
				ps = 1'b1;
			end
		end else if (!is_data || ps) begin
			bad = 1'b1;
		end
		if (!bad) begin
			if (grp_pos == GRP_LAST_POS) bad = ps && !ch.end_of_string;
			else bad = ch.end_of_string;
		end
		if (bad) begin
			if (ch.end_of_string) begin
				add_expected('{data_byte: 8'h00, last: 1'b1, error: 1'b1});
				clear_group();
			end else begin
				str_err = 1'b1;
			end
		end else if (grp_pos != GRP_LAST_POS) begin
			grp_acc  = {grp_acc[11:0], v};
			grp_pos  = grp_pos + 1'b1;
			pad_cnt  = pc;
			pad_seen = ps;
		end else begin
			word = {grp_acc, v};
			n = 3 - pc;
			for (int k = 0; k < n; k++)
				add_expected('{data_byte: word[23 - 8 * k -: 8],
					last: (k == n - 1) ? ch.end_of_string : 1'b0, error: 1'b0});
			clear_group();
		end
	endtask

	task automatic report_error(input string msg);
		if (err_count < PRINT_CAP) $display("tb: mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	always @(posedge clk) begin : monitor
		res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (decoded_bytes.size() == 0) begin
					report_error($sformatf("result %h with nothing expected", res_data));
				end else begin
					want = decoded_bytes.pop_front();
					if (res_data.data_byte !== want.data_byte)
						report_error($sformatf("data_byte %h, expected %h",
							res_data.data_byte, want.data_byte));
					if (res_data.last !== want.last)
						report_error($sformatf("last %b, expected %b", res_data.last, want.last));
					if (res_data.error !== want.error)
						report_error($sformatf("error %b, expected %b",
							res_data.error, want.error));
				end
			end
			if (char_valid && !char_stall) decode_char(char_data);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (char_valid && !char_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin : receiver
		int run;
		run = 1;
		forever begin
			repeat (run) @(posedge clk);
			if (hold_off_len > 0) begin
				run = hold_off_len;
				hold_off_len = 0;
				res_stall <= 1'b1;
			end else begin
				run = $urandom_range(1, 6);
				case (rx_mode)
					RX_OPEN:  res_stall <= 1'b0;
					RX_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
					default:  res_stall <= ($urandom_range(0, 1) == 1);
				endcase
			end
		end
	end

	task automatic send_char(input logic [7:0] c, input logic eos);
		int gap;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = 0;
			if (!sender_gapless && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 5);
			if (gap > 0) begin
				char_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		char_valid <= 1'b1;
		char_data  <= '{char_code: c, end_of_string: eos};
		do @(posedge clk); while (char_stall);
		burst_left--;
	endtask

	task automatic send_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++) send_char(s[i], close && i == s.len() - 1);
	endtask

	task automatic wait_all_decoded();
		char_valid <= 1'b0;
		do @(posedge clk); while (decoded_bytes.size() != 0);
		burst_left = 0;
	endtask

	task automatic test_full_groups();
		send_text("AZaz09+/", 1'b1);
		wait_all_decoded();
	endtask

	task automatic test_padding();
		send_text("TR==", 1'b1);
		send_text("TWF=", 1'b1);
		wait_all_decoded();
	endtask

	task automatic test_malformed();
		send_text("=", 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b1);
		send_text("A=", 1'b1);
		send_text("AB=C", 1'b1);
		send_text("AB==", 1'b0);
		send_text("Q", 1'b1);
		send_text("QQ", 1'b1);
		wait_all_decoded();
	endtask

	task automatic test_backpressure();
		sender_gapless = 1'b1;
		hold_off_len = 80;
		for (int g = 0; g < 6; g++)
			for (int k = 0; k < 4; k++) send_char(rand_b64(), g == 5 && k == 3);
		sender_gapless = 1'b0;
		wait_all_decoded();
	endtask

	task automatic test_random_strings(input int n_items);
		logic [7:0] text[$];
		int         sent;
		int         groups;
		int         pads;
		int         kind;
		int         n;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 9);
			rx_mode = rx_mode_e'($urandom_range(0, 2));
			sender_gapless = ($urandom_range(0, 3) == 0);
			text.delete();
			if (kind == 9) begin
				n = $urandom_range(1, 9);
				repeat (n) begin
					case ($urandom_range(0, 2))
						0:       text = {text, PAD_CHAR};
						1:       text = {text, rand_b64()};
						default: text = {text, 8'($urandom_range(0, 255))};
					endcase
				end
			end else begin
				groups = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 8) : $urandom_range(1, 2);
				repeat (4 * groups) text = {text, rand_b64()};
				pads = $urandom_range(0, 2);
				for (int i = 0; i < pads; i++) text[text.size() - 1 - i] = PAD_CHAR;
				if (kind == 8) text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
				if (kind == 7) begin
					if ($urandom_range(0, 1) == 1) void'(text.pop_back());
					else text = {text, rand_b64()};
				end
				if (kind == 6 && groups > 1) text[3] = PAD_CHAR;
			end
			foreach (text[i]) send_char(text[i], i == text.size() - 1);
			sent += text.size();
			if ($urandom_range(0, 9) == 0) wait_all_decoded();
		end
		sender_gapless = 1'b0;
		rx_mode = RX_LIGHT;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_full_groups();
		test_padding();
		test_malformed();
		test_backpressure();
		test_random_strings(170);
		wait_all_decoded();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (err_count == 0) $display("tb: done, clean");
		else $display("tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/b64sd_pkg.sv
src/b64sd_front.sv
src/b64sd_queue.sv
src/b64sd_back.sv
src/base64_stream_decoder_unit.sv
test/tb.sv
